// File: rtl/mcfs_pkg.sv
// ----------------------------------------------------------------------------
// mcfs_pkg
// Shared types and constants for the multi-channel frame sequencer.
// ----------------------------------------------------------------------------
package mcfs_pkg;

  typedef enum logic [1:0] {
    OP_CONFIG  = 2'd0,
    OP_FRAME   = 2'd1,
    OP_TICK    = 2'd2,
    OP_RESTORE = 2'd3
  } op_e;

  // loop modes; any other code behaves as clamp
  localparam logic [1:0] MODE_WRAP     = 2'd1;
  localparam logic [1:0] MODE_PINGPONG = 2'd2;

  localparam int COUNT_W      = 6;
  localparam int CHANNEL_W    = 4;
  localparam int MAX_RESULTS  = 16;
  localparam int RESULT_CNT_W = 5;

  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = 2;
  localparam int QCNT_W       = 3;

  typedef struct packed {
    op_e                  op;
    logic [CHANNEL_W-1:0] channel;
    logic [4:0]           frame_index;
    logic [31:0]          handle;
    logic [COUNT_W-1:0]   frame_count;
    logic [15:0]          period_ticks;
    logic [1:0]           loop_mode;
    logic [31:0]          now;
  } item_t;

  typedef struct packed {
    logic [CHANNEL_W-1:0] out_channel;
    logic [31:0]          out_handle;
    logic                 last;
  } result_t;

endpackage

// File: rtl/mcfs_front.sv
// ----------------------------------------------------------------------------
// mcfs_front
// Accepts command beats, drops writes to absent channels or slots, saturates
// the frame count and queues the rest for the back end.
// ----------------------------------------------------------------------------
module mcfs_front #(
  parameter int CHANNELS   = 16,
  parameter int MAX_FRAMES = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  mcfs_pkg::item_t item_i,
  output logic            busy,
  output logic            cmd_valid_o,
  input  logic            cmd_ready_i,
  output mcfs_pkg::item_t cmd_o
);

  localparam int CntW   = mcfs_pkg::COUNT_W;
  localparam int QDepth = mcfs_pkg::QUEUE_DEPTH;
  localparam int QPtrW  = mcfs_pkg::QPTR_W;
  localparam int QCntW  = mcfs_pkg::QCNT_W;

  mcfs_pkg::item_t cls;
  logic            keep;
  logic            push;
  logic            pop;

  mcfs_pkg::item_t q_mem [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  always_comb begin
    cls = item_i;
    if (32'(item_i.frame_count) > 32'(MAX_FRAMES)) begin
      cls.frame_count = CntW'(MAX_FRAMES);
    end
    case (item_i.op)
      mcfs_pkg::OP_CONFIG: begin
        keep = 32'(item_i.channel) < 32'(CHANNELS);
      end
      mcfs_pkg::OP_FRAME: begin
        keep = (32'(item_i.channel) < 32'(CHANNELS)) &&
               (32'(item_i.frame_index) < 32'(MAX_FRAMES));
      end
      default: begin
        keep = 1'b1;
      end
    endcase
  end

  assign busy        = (cnt_q == QCntW'(QDepth));
  assign push        = start && !busy && keep;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + QCntW'(1);
        2'b01:   cnt_q <= cnt_q - QCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: rtl/mcfs_back.sv
// ----------------------------------------------------------------------------
// mcfs_back
// Executes queued commands: table writes as they leave the queue, ticks and restores as a
// three-stage walk over the channels (state read, step, frame read and emit).
// ----------------------------------------------------------------------------
module mcfs_back #(
  parameter int CHANNELS   = 16,
  parameter int MAX_FRAMES = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  mcfs_pkg::item_t   cmd_i,
  output logic              result_valid_o,
  output mcfs_pkg::result_t result_o
);

  localparam int CW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int FW     = $clog2(MAX_FRAMES);
  localparam int AW     = CW + FW;
  localparam int FDepth = CHANNELS << FW;
  localparam int CntW   = mcfs_pkg::COUNT_W;
  localparam int XW     = ((FW > CntW) ? FW : CntW) + 1;
  localparam int RcW    = mcfs_pkg::RESULT_CNT_W;
  localparam int ChOutW = mcfs_pkg::CHANNEL_W;

  typedef struct packed {
    logic [CntW-1:0] count;
    logic [15:0]     period;
    logic [1:0]      mode;
    logic [FW-1:0]   cur;
    logic            back;
    logic [31:0]     last_swap;
  } chan_t;

  typedef enum logic [1:0] {
    IDLE,
    WALK,
    DRAIN
  } state_e;

  state_e            state_q;
  logic              restore_q;
  logic [31:0]       now_q;
  logic [CW-1:0]     idx_q;
  logic [CHANNELS-1:0] active_q;

  logic              a_vld_q;
  logic [CW-1:0]     a_ch_q;
  logic              a_act_q;
  logic              b_vld_q;
  logic [CW-1:0]     b_ch_q;

  logic              pend_vld_q;
  mcfs_pkg::result_t pend_q;
  logic [RcW-1:0]    rcnt_q;
  logic              out_vld_q;
  mcfs_pkg::result_t out_q;

  chan_t             st_mem [CHANNELS];
  chan_t             st_rd_q;
  logic [31:0]       fr_mem [FDepth];
  logic [31:0]       fr_rd_q;

  logic              pop;
  logic [31:0]       elapsed;
  logic              due;
  logic [XW-1:0]     cur_x, cnt_x, nf_x;
  logic              nback;
  logic [FW-1:0]     nf;
  logic              st_we;
  logic [CW-1:0]     st_waddr;
  chan_t             st_wdata;
  logic              fr_we;
  logic [AW-1:0]     fr_waddr;
  logic [AW-1:0]     fr_raddr;
  logic              cand;
  logic              flush;

  assign cmd_ready_o = (state_q == IDLE);
  assign pop         = cmd_valid_i && cmd_ready_o;

  // step decision for the channel in the second stage
  assign elapsed = now_q - st_rd_q.last_swap;
  assign due     = a_act_q && (st_rd_q.count >= CntW'(2)) &&
                   (elapsed >= 32'(st_rd_q.period));

  always_comb begin
    cur_x = XW'(st_rd_q.cur);
    cnt_x = XW'(st_rd_q.count);
    if (cur_x >= cnt_x) begin
      cur_x = cnt_x - XW'(1);
    end
    nback = st_rd_q.back;
    case (st_rd_q.mode)
      mcfs_pkg::MODE_PINGPONG: begin
        if (st_rd_q.back) begin
          if (cur_x == '0) begin
            nback = 1'b0;
            nf_x  = XW'(1);
          end else begin
            nf_x = cur_x - XW'(1);
          end
        end else if (cur_x + XW'(1) >= cnt_x) begin
          nback = 1'b1;
          nf_x  = cnt_x - XW'(2);
        end else begin
          nf_x = cur_x + XW'(1);
        end
      end
      mcfs_pkg::MODE_WRAP: begin
        if (st_rd_q.back) begin
          nf_x = (cur_x == '0) ? cnt_x - XW'(1) : cur_x - XW'(1);
        end else begin
          nf_x = (cur_x + XW'(1) >= cnt_x) ? '0 : cur_x + XW'(1);
        end
      end
      default: begin
        // clamp: hold at either end
        if (st_rd_q.back) begin
          nf_x = (cur_x == '0) ? '0 : cur_x - XW'(1);
        end else begin
          nf_x = (cur_x + XW'(1) >= cnt_x) ? cnt_x - XW'(1) : cur_x + XW'(1);
        end
      end
    endcase
    nf = FW'(nf_x);
  end

  // channel table write port: configure when idle, step write-back in a walk
  always_comb begin
    st_we    = 1'b0;
    st_waddr = a_ch_q;
    st_wdata = st_rd_q;
    if (pop && (cmd_i.op == mcfs_pkg::OP_CONFIG)) begin
      st_we              = 1'b1;
      st_waddr           = CW'(cmd_i.channel);
      st_wdata.count     = cmd_i.frame_count;
      st_wdata.period    = cmd_i.period_ticks;
      st_wdata.mode      = cmd_i.loop_mode;
      st_wdata.cur       = '0;
      st_wdata.back      = 1'b0;
      st_wdata.last_swap = cmd_i.now;
    end else if (a_vld_q && !restore_q && due) begin
      st_we              = 1'b1;
      st_wdata.cur       = nf;
      st_wdata.back      = nback;
      st_wdata.last_swap = now_q;
    end
  end

  assign fr_we    = pop && (cmd_i.op == mcfs_pkg::OP_FRAME);
  assign fr_waddr = {CW'(cmd_i.channel), FW'(cmd_i.frame_index)};
  assign fr_raddr = {a_ch_q, restore_q ? {FW{1'b0}} : nf};

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    st_rd_q <= st_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (fr_we) begin
      fr_mem[fr_waddr] <= cmd_i.handle;
    end
    fr_rd_q <= fr_mem[fr_raddr];
  end

  // third stage: a zero handle is only reported by a restore
  assign cand  = b_vld_q && (restore_q || (fr_rd_q != '0)) &&
                 (rcnt_q < RcW'(mcfs_pkg::MAX_RESULTS));
  assign flush = (state_q == DRAIN) && !a_vld_q && !b_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= IDLE;
      restore_q  <= 1'b0;
      now_q      <= '0;
      idx_q      <= '0;
      active_q   <= '0;
      a_vld_q    <= 1'b0;
      a_ch_q     <= '0;
      a_act_q    <= 1'b0;
      b_vld_q    <= 1'b0;
      b_ch_q     <= '0;
      pend_vld_q <= 1'b0;
      pend_q     <= '0;
      rcnt_q     <= '0;
      out_vld_q  <= 1'b0;
      out_q      <= '0;
    end else begin
      // first stage
      a_vld_q <= (state_q == WALK);
      a_ch_q  <= idx_q;
      a_act_q <= active_q[idx_q];

      // second stage
      b_vld_q <= a_vld_q && (restore_q ? a_act_q : due);
      b_ch_q  <= a_ch_q;
      if (a_vld_q && restore_q) begin
        active_q[a_ch_q] <= 1'b0;
      end

      // hold one result back so the final one can carry last
      out_vld_q <= pend_vld_q && (cand || flush);
      if (cand) begin
        if (pend_vld_q) begin
          out_q <= pend_q;
        end
        pend_vld_q <= 1'b1;
        pend_q     <= {ChOutW'(b_ch_q), fr_rd_q, 1'b0};
        rcnt_q     <= rcnt_q + RcW'(1);
      end

      case (state_q)
        IDLE: begin
          if (pop) begin
            case (cmd_i.op)
              mcfs_pkg::OP_CONFIG: begin
                active_q[CW'(cmd_i.channel)] <= 1'b1;
              end
              mcfs_pkg::OP_TICK, mcfs_pkg::OP_RESTORE: begin
                restore_q <= (cmd_i.op == mcfs_pkg::OP_RESTORE);
                now_q     <= cmd_i.now;
                idx_q     <= '0;
                rcnt_q    <= '0;
                state_q   <= WALK;
              end
              default: begin
              end
            endcase
          end
        end
        WALK: begin
          if (idx_q == CW'(CHANNELS - 1)) begin
            state_q <= DRAIN;
          end else begin
            idx_q <= idx_q + CW'(1);
          end
        end
        DRAIN: begin
          if (flush) begin
            if (pend_vld_q) begin
              out_q      <= {pend_q.out_channel, pend_q.out_handle, 1'b1};
              pend_vld_q <= 1'b0;
            end
            state_q <= IDLE;
          end
        end
        default: begin
          state_q <= IDLE;
        end
      endcase
    end
  end

  assign result_valid_o = out_vld_q;
  assign result_o       = out_q;

endmodule

// File: rtl/multi_channel_frame_sequencer.sv
// A configure or frame write is written into its table as it leaves the queue.
// A tick or restore occupies the back end for a walk over the channels, one channel per
// cycle, and a drain of the pipeline behind it; the back end takes no new command until
// it is idle again, and results stream out while the walk goes on.
// The front queue holds four beats, so start is taken while a walk is running until the queue is full.
// Reset clears the queue, the sequencer and all active flags; tables need no clearing.
// ----------------------------------------------------------------------------
// multi_channel_frame_sequencer
// Animation frame sequencer: per-channel frame tables, periods and loop modes,
// stepped by tick commands and reported as a stream of handle updates.
// ----------------------------------------------------------------------------
module multi_channel_frame_sequencer #(
  parameter int CHANNELS   = 16,
  parameter int MAX_FRAMES = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  mcfs_pkg::item_t   item_i,
  output logic              busy,
  output logic              result_valid_o,
  output mcfs_pkg::result_t result_o
);

  logic            cmd_valid;
  logic            cmd_ready;
  mcfs_pkg::item_t cmd;

  mcfs_front #(
    .CHANNELS   (CHANNELS),
    .MAX_FRAMES (MAX_FRAMES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .item_i      (item_i),
    .busy        (busy),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  mcfs_back #(
    .CHANNELS   (CHANNELS),
    .MAX_FRAMES (MAX_FRAMES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_ready_o    (cmd_ready),
    .cmd_i          (cmd),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

// File: rtl/mcfs_checker.sv
// ----------------------------------------------------------------------------
// mcfs_checker
// Port-level checks on the sequencer: quiet and not busy after reset, channel order of
// the results of one command, channel range of every result.
// ----------------------------------------------------------------------------
module mcfs_checker #(
  parameter int CHANNELS = 16
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input mcfs_pkg::item_t   item_i,
  input logic              busy,
  input logic              result_valid_o,
  input mcfs_pkg::result_t result_o
);

  logic unused_inputs;
  assign unused_inputs = start ^ (^item_i);

  a_quiet_after_reset : assert property (@(posedge clk_i)
    !rst_ni |=> !result_valid_o)
    else $error("result beat straight after reset");

  a_ready_after_reset : assert property (@(posedge clk_i)
    !rst_ni |=> !busy)
    else $error("busy straight after reset");

  // back-to-back results of one command come out in rising channel order
  a_channel_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((CHANNELS <= 16) && result_valid_o && !result_o.last) ##1 result_valid_o
      |-> (result_o.out_channel > $past(result_o.out_channel)))
    else $error("results of one command out of channel order");

  a_channel_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (CHANNELS < 16))
      |-> (32'(result_o.out_channel) < 32'(CHANNELS)))
    else $error("result for a channel that does not exist");

endmodule

bind multi_channel_frame_sequencer mcfs_checker #(
  .CHANNELS (CHANNELS)
) u_mcfs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .item_i         (item_i),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
